### hw/rtl/decimating_current_averager_macros.svh
// assertion macros used by the averager controller
`ifndef DECIMATING_CURRENT_AVERAGER_MACROS_SVH
`define DECIMATING_CURRENT_AVERAGER_MACROS_SVH

// same-cycle implication, checked outside reset
`define DCA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dca check failed");

// next-cycle implication, checked outside reset
`define DCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dca check failed");

`endif

### hw/rtl/dca_pkg.sv
// shared types, widths and constants of the current averager
package dca_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int IN_DATA_W  = 16;
    localparam int CUR_W      = 18;
    localparam int ACC_W      = 22;
    localparam int OUT_DATA_W = 40;
    localparam int BPR_W      = 11;
    localparam int SCALE_W    = 32;
    localparam int OFF_W      = 17;
    localparam int PROD_W     = ACC_W + SCALE_W;
    localparam int FRAC_BITS  = 24;
    localparam int Q_W        = PROD_W - FRAC_BITS + 1;
    localparam int DIFF_W     = Q_W + 2;
    localparam int CUR_LIMIT  = 100000;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    localparam logic [1:0] REG_BLOCKS = 2'd0;
    localparam logic [1:0] REG_SCALE  = 2'd1;
    localparam logic [1:0] REG_OFFSET = 2'd2;

    localparam logic [BPR_W-1:0]   BLOCKS_RST = BPR_W'(16);
    localparam logic [SCALE_W-1:0] SCALE_RST  = SCALE_W'(1000000);
    localparam logic [OFF_W-1:0]   OFFSET_RST = '0;

    typedef struct packed {
        logic [BPR_W-1:0]   blocks_per_result;
        logic [SCALE_W-1:0] scale_q24;
        logic [OFF_W-1:0]   offset_ma;
    } t_cfg;

    typedef struct packed {
        logic sample;
        logic restart;
        logic div_load;
        logic div_step;
        logic acc_upd;
        logic mul;
        logic rnd;
        logic clmp;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic blk_done;
    } t_dp_status;

    // width of a full burst sum
    function automatic int sum_width(input int max_burst);
        return $clog2(max_burst * ((2 ** SAMPLE_W) - 1) + 1);
    endfunction

endpackage

### hw/rtl/decimating_current_averager.sv
// Current averager top level: averages ADC bursts, decimates blocks, scales to milliamps.
// Input stream: one word per ADC sample; tuser set means restart (clears the burst sum,
// burst count, block accumulator and block counter), tlast marks the last sample of a
// burst. Samples beyond MAX_BURST in one burst are dropped, their tlast still counts.
// Output stream: one word per completed block of blocks_per_result bursts (0 taken as 1, at most
// MAX_BLOCKS), carrying the signed current in mA and the latched block sum.
// Timing: a sample without tlast or a restart is taken while idle and leaves the engine idle. A
// burst end runs a one-bit-per-cycle divider of sum_width(MAX_BURST) steps (15 at defaults)
// and then an accumulate step; no new word is taken until these are done. A block end adds a
// multiply, round, clamp and output load before the word shows on the output.
// The output register holds one word; new input is taken while it waits. If a block
// completes while that word is still not taken, the engine holds until it is.
// Reset restores the registers to their defaults and clears all accumulation. The user must
// write the configuration port only while the block is idle; the block does not enforce it.
module decimating_current_averager import dca_pkg::*; #(
    parameter int MAX_BURST  = 8,
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [11:0] sample
    input  logic                  s_axis_tuser,  // [0] cmd
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [17:0] current_ma, [39:18] block_sum
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg       w_cfg;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    dca_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dca_ctrl #(
        .MAX_BURST (MAX_BURST)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_restart (s_axis_tuser),
        .i_in_last    (s_axis_tlast),
        .o_in_ready   (s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_cmd        (w_cmd),
        .i_status     (w_status)
    );

    dca_dp #(
        .MAX_BURST  (MAX_BURST),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_cfg    (w_cfg),
        .i_sample (s_axis_tdata[SAMPLE_W-1:0]),
        .o_status (w_status),
        .o_data   (m_axis_tdata)
    );

endmodule

### hw/rtl/dca_regs.sv
// apb configuration registers of the current averager
module dca_regs import dca_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blocks_per_result <= BLOCKS_RST;
            r_cfg.scale_q24         <= SCALE_RST;
            r_cfg.offset_ma         <= OFFSET_RST;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_BLOCKS: r_cfg.blocks_per_result <= pwdata[BPR_W-1:0];
                REG_SCALE:  r_cfg.scale_q24         <= pwdata[SCALE_W-1:0];
                REG_OFFSET: r_cfg.offset_ma         <= pwdata[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BLOCKS: prdata = CFG_DATA_W'(r_cfg.blocks_per_result);
            REG_SCALE:  prdata = CFG_DATA_W'(r_cfg.scale_q24);
            REG_OFFSET: prdata = CFG_DATA_W'(r_cfg.offset_ma);
            default:    prdata = '0;
        endcase
    end

endmodule

### hw/rtl/dca_dp.sv
// datapath: burst sum, serial divider, block accumulator, scaling and clamp
module dca_dp import dca_pkg::*; #(
    parameter int MAX_BURST  = 8,
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  t_cfg                  i_cfg,
    input  logic [SAMPLE_W-1:0]   i_sample,
    output t_dp_status            o_status,
    output logic [OUT_DATA_W-1:0] o_data
);

    localparam int CNT_W = $clog2(MAX_BURST + 1);
    localparam int SUM_W = sum_width(MAX_BURST);
    localparam int IDX_W = $clog2(MAX_BLOCKS + 1);
    localparam logic signed [DIFF_W-1:0] LIM_P = DIFF_W'(CUR_LIMIT);
    localparam logic signed [DIFF_W-1:0] LIM_N = -LIM_P;

    logic [SUM_W-1:0]  r_sum, w_sum;
    logic [CNT_W-1:0]  r_cnt, w_cnt;
    logic [ACC_W-1:0]  r_acc, r_latched, w_acc_sat;
    logic [ACC_W:0]    w_acc_sum;
    logic [IDX_W-1:0]  r_idx, w_idx_inc, w_eff;
    logic [SUM_W-1:0]  r_dq;
    logic [CNT_W-1:0]  r_rem, r_dvs;
    logic [CNT_W:0]    w_shift;
    logic              w_qbit;
    logic [PROD_W-1:0] r_prod;
    logic [Q_W-1:0]    r_q;
    logic signed [DIFF_W-1:0] w_diff;
    logic [CUR_W-1:0]  r_cur, r_out_cur;
    logic [ACC_W-1:0]  r_out_sum;

    // burst accumulate, samples past the burst limit are dropped
    always_comb begin
        w_sum = r_sum;
        w_cnt = r_cnt;
        if (r_cnt < CNT_W'(MAX_BURST)) begin
            w_sum = r_sum + SUM_W'(i_sample);
            w_cnt = r_cnt + CNT_W'(1);
        end
    end

    // restoring divider, one quotient bit per step
    assign w_shift = {r_rem, r_dq[SUM_W-1]};
    assign w_qbit  = (w_shift >= {1'b0, r_dvs});

    assign w_acc_sum = {1'b0, r_acc} + (ACC_W + 1)'(r_dq);
    assign w_acc_sat = w_acc_sum[ACC_W] ? ACC_MAX : w_acc_sum[ACC_W-1:0];

    always_comb begin
        if (i_cfg.blocks_per_result == '0) begin
            w_eff = IDX_W'(1);
        end else if (32'(i_cfg.blocks_per_result) > 32'(MAX_BLOCKS)) begin
            w_eff = IDX_W'(MAX_BLOCKS);
        end else begin
            w_eff = IDX_W'(i_cfg.blocks_per_result);
        end
    end

    assign w_idx_inc         = r_idx + IDX_W'(1);
    assign o_status.blk_done = (w_idx_inc >= w_eff);

    assign w_diff = $signed({{(DIFF_W - OFF_W){1'b0}}, i_cfg.offset_ma})
                  - $signed({{(DIFF_W - Q_W){1'b0}}, r_q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
            r_acc <= '0;
            r_idx <= '0;
        end else if (i_cmd.restart) begin
            r_sum <= '0;
            r_cnt <= '0;
            r_acc <= '0;
            r_idx <= '0;
        end else if (i_cmd.sample) begin
            if (i_cmd.div_load) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= w_sum;
                r_cnt <= w_cnt;
            end
        end else if (i_cmd.acc_upd) begin
            if (o_status.blk_done) begin
                r_acc <= '0;
                r_idx <= '0;
            end else begin
                r_acc <= w_acc_sat;
                r_idx <= w_idx_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dq  <= w_sum;
            r_rem <= '0;
            r_dvs <= w_cnt;
        end else if (i_cmd.div_step) begin
            r_dq  <= {r_dq[SUM_W-2:0], w_qbit};
            r_rem <= w_qbit ? CNT_W'(w_shift - {1'b0, r_dvs}) : w_shift[CNT_W-1:0];
        end
        if (i_cmd.acc_upd && o_status.blk_done) begin
            r_latched <= w_acc_sat;
        end
        if (i_cmd.mul) begin
            r_prod <= r_latched * i_cfg.scale_q24;
        end
        if (i_cmd.rnd) begin
            // round half up, drop the fraction
            r_q <= Q_W'((r_prod + PROD_W'(1) * (PROD_W'(1) << (FRAC_BITS - 1)))
                        >> FRAC_BITS);
        end
        if (i_cmd.clmp) begin
            if (w_diff > LIM_P) begin
                r_cur <= CUR_W'(LIM_P);
            end else if (w_diff < LIM_N) begin
                r_cur <= CUR_W'(LIM_N);
            end else begin
                r_cur <= CUR_W'(w_diff);
            end
        end
        if (i_cmd.out_load) begin
            r_out_cur <= r_cur;
            r_out_sum <= r_latched;
        end
    end

    assign o_data = {r_out_sum, r_out_cur};

endmodule

### hw/rtl/dca_ctrl.sv
// controller: sequences divide, accumulate, scale, round, clamp and output load
module dca_ctrl import dca_pkg::*; #(
    parameter int MAX_BURST = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_restart,
    input  logic       i_in_last,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    `include "decimating_current_averager_macros.svh"

    localparam int SUM_W  = sum_width(MAX_BURST);
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_RND  = 3'd4;
    localparam logic [2:0] S_CLMP = 3'd5;
    localparam logic [2:0] S_HOLD = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              w_acc_in, w_out_free, w_div_end;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_acc_in    = i_in_valid & o_in_ready;
    assign w_out_free  = ~r_out_valid | i_out_ready;
    assign w_div_end   = (r_step == STEP_W'(SUM_W - 1));

    always_comb begin
        o_cmd          = '0;
        o_cmd.restart  = w_acc_in & i_in_restart;
        o_cmd.sample   = w_acc_in & ~i_in_restart;
        o_cmd.div_load = w_acc_in & ~i_in_restart & i_in_last;
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.acc_upd  = (r_state == S_ACC);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.rnd      = (r_state == S_RND);
        o_cmd.clmp     = (r_state == S_CLMP);
        o_cmd.out_load = (r_state == S_HOLD) & w_out_free;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.div_load) begin
                    n_state = S_DIV;
                    n_step  = '0;
                end
            end
            S_DIV: begin
                n_step = r_step + STEP_W'(1);
                if (w_div_end) begin
                    n_state = S_ACC;
                end
            end
            S_ACC:  n_state = i_status.blk_done ? S_MUL : S_IDLE;
            S_MUL:  n_state = S_RND;
            S_RND:  n_state = S_CLMP;
            S_CLMP: n_state = S_HOLD;
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    `DCA_ASSERT_NEXT(a_last_starts_div, i_clk, i_rst_n, o_cmd.div_load, r_state == S_DIV)
    `DCA_ASSERT_NEXT(a_div_len, i_clk, i_rst_n, (r_state == S_DIV) && w_div_end,
                     r_state == S_ACC)
    `DCA_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, o_cmd.out_load,
                     r_out_valid && (r_state == S_IDLE))
    `DCA_ASSERT_IMPL(a_busy_no_take, i_clk, i_rst_n, r_state != S_IDLE,
                     !o_cmd.sample && !o_cmd.restart)

endmodule
